// ===== src/tsr_pkg.sv =====
// Package for the triangle span rasterizer: field widths and shared types.
// No dependencies; the channels, the rasterizer, the divider and the testbench import it.
package tsr_pkg;

   localparam int WORD_W  = 32;  // fixed point fields
   localparam int COORD_W = 16;  // integer row and x fields
   localparam int COLOR_W = 8;
   localparam int ROWS_W  = 7;   // holds the hard row limit of 64
   localparam int ROW_CAP = 64;

   // Handshake between the sequencer and the divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== src/tsr_channels.sv =====
// Channel interfaces of the span rasterizer: triangle input and span output.
// Depends on tsr_pkg for the field widths.
interface tsr_req_if
   import tsr_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [WORD_W-1:0]  tip_x;
   logic signed [WORD_W-1:0]  tip_y;
   logic signed [WORD_W-1:0]  tip_depth;
   logic signed [WORD_W-1:0]  end_row;
   logic signed [WORD_W-1:0]  left_x_slope;
   logic signed [WORD_W-1:0]  right_x_slope;
   logic signed [WORD_W-1:0]  left_z_slope;
   logic signed [WORD_W-1:0]  right_z_slope;
   logic [COLOR_W-1:0]        paint_color;
   logic                      upward;

   modport source (output valid, tip_x, tip_y, tip_depth, end_row, left_x_slope,
                   right_x_slope, left_z_slope, right_z_slope, paint_color, upward,
                   input ready);
   modport sink (input valid, tip_x, tip_y, tip_depth, end_row, left_x_slope,
                 right_x_slope, left_z_slope, right_z_slope, paint_color, upward,
                 output ready);
endinterface

interface tsr_rsp_if
   import tsr_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] row;
   logic signed [COORD_W-1:0] x_first;
   logic signed [COORD_W-1:0] x_final;
   logic signed [WORD_W-1:0]  depth_start;
   logic signed [WORD_W-1:0]  depth_step;
   logic [COLOR_W-1:0]        span_color;
   logic                      last;
   logic                      truncated;

   modport source (output valid, row, x_first, x_final, depth_start, depth_step,
                   span_color, last, truncated, input ready);
   modport sink (input valid, row, x_first, x_final, depth_start, depth_step,
                 span_color, last, truncated, output ready);
endinterface

// ===== src/triangle_span_rasterizer.sv =====
// Triangle span rasterizer: one flat-based triangle half in, one span per row out.
// Depends on tsr_pkg, tsr_channels (tsr_req_if, tsr_rsp_if) and tsr_div.
//
// A triangle is taken when req_bus.ready is high, only while no triangle is being
// walked. After the transfer, S_ROUND rounds the tip and end rows and S_COUNT sizes
// the walk. Each row then runs one bit-serial division for the depth step over a
// dividend of WORD_W + 1 + FRAC_BITS bits: S_DIV_START starts it, S_DIV_WAIT waits
// for the divider's done flag and S_EMIT hands off the span. A span waits in the
// output register while the next row divides; a row whose division ends while the
// previous span still waits holds until that span is taken.
// At most MAX_ROWS spans are sent; when rows were dropped every span carries
// truncated. A walk with no rows sends nothing.
module triangle_span_rasterizer
   import tsr_pkg::*;
#(
   parameter int MAX_ROWS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   tsr_req_if.sink     req_bus,
   tsr_rsp_if.source   rsp_bus
);
   localparam int ACC_W = WORD_W + 2;   // room for rounding and row arithmetic

   typedef enum logic [2:0] {
      S_IDLE, S_ROUND, S_COUNT, S_DIV_START, S_DIV_WAIT, S_EMIT
   } state_type;

   function automatic logic signed [ACC_W-1:0] round_fix(input logic signed [WORD_W-1:0] v);
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] r;
      mag = v[WORD_W-1] ? -ACC_W'(v) : ACC_W'(v);
      r   = (mag + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[WORD_W-1] ? -r : r;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
      if (v > ACC_W'(signed'(32767)))
         return COORD_W'(32767);
      else if (v < -ACC_W'(signed'(32768)))
         return {1'b1, {(COORD_W-1){1'b0}}};
      else
         return v[COORD_W-1:0];
   endfunction

   function automatic logic signed [WORD_W-1:0] sat_step(input logic signed [WORD_W-1:0] a,
                                                          input logic signed [WORD_W-1:0] b,
                                                          input logic sub);
      logic signed [WORD_W:0] s;
      s = sub ? ({a[WORD_W-1], a} - {b[WORD_W-1], b}) : ({a[WORD_W-1], a} + {b[WORD_W-1], b});
      if (s[WORD_W] != s[WORD_W-1])
         return s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      else
         return s[WORD_W-1:0];
   endfunction

   state_type                  state_ff, state_in;
   // triangle parameters
   logic signed [WORD_W-1:0]   tip_x_ff, tip_y_ff, tip_z_ff, end_ff;
   logic signed [WORD_W-1:0]   lxs_ff, rxs_ff, lzs_ff, rzs_ff;
   logic [COLOR_W-1:0]         color_ff;
   logic                       up_ff;
   // walk state
   logic signed [ACC_W-1:0]    r0_ff, r0_in, r1_ff, r1_in;
   logic signed [ACC_W-1:0]    row_ff, row_in;
   logic signed [WORD_W-1:0]   lx_ff, lx_in, rx_ff, rx_in, lz_ff, lz_in, rz_ff, rz_in;
   logic [ROWS_W-1:0]          left_ff, left_in;
   logic                       trunc_ff, trunc_in;
   logic                       zero_w_ff, zero_w_in;
   // output register
   logic                       ov_ff, ov_in;
   logic signed [COORD_W-1:0]  o_row_ff, o_row_in, o_xf_ff, o_xf_in, o_xl_ff, o_xl_in;
   logic signed [WORD_W-1:0]   o_dz_ff, o_dz_in, o_step_ff, o_step_in;
   logic                       o_last_ff, o_last_in;

   logic                       accept;
   logic signed [ACC_W:0]      count;
   logic                       div_start;
   logic signed [WORD_W:0]     div_num;
   logic signed [WORD_W:0]     div_den;
   logic signed [WORD_W-1:0]   div_q;
   div_status_type             div_st;

   assign accept = req_bus.valid && req_bus.ready;

   assign count = up_ff ? ({r0_ff[ACC_W-1], r0_ff} - {r1_ff[ACC_W-1], r1_ff} + 1'b1)
                        : ({r1_ff[ACC_W-1], r1_ff} - {r0_ff[ACC_W-1], r0_ff} + 1'b1);

   assign div_num = {rz_ff[WORD_W-1], rz_ff} - {lz_ff[WORD_W-1], lz_ff};
   assign div_den = {rx_ff[WORD_W-1], rx_ff} - {lx_ff[WORD_W-1], lx_ff};

   tsr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .quot   (div_q),
      .status (div_st)
   );

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      r0_in     = r0_ff;
      r1_in     = r1_ff;
      row_in    = row_ff;
      lx_in     = lx_ff;
      rx_in     = rx_ff;
      lz_in     = lz_ff;
      rz_in     = rz_ff;
      left_in   = left_ff;
      trunc_in  = trunc_ff;
      zero_w_in = zero_w_ff;
      ov_in     = ov_ff && !rsp_bus.ready;
      o_row_in  = o_row_ff;
      o_xf_in   = o_xf_ff;
      o_xl_in   = o_xl_ff;
      o_dz_in   = o_dz_ff;
      o_step_in = o_step_ff;
      o_last_in = o_last_ff;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept)
               state_in = S_ROUND;
         end
         S_ROUND: begin
            r0_in    = round_fix(tip_y_ff);
            r1_in    = round_fix(end_ff);
            state_in = S_COUNT;
         end
         S_COUNT: begin
            if (count <= 0) begin
               state_in = S_IDLE;
            end else begin
               trunc_in = count > (ACC_W+1)'(MAX_ROWS);
               left_in  = trunc_in ? ROWS_W'(MAX_ROWS) : count[ROWS_W-1:0];
               lx_in    = tip_x_ff;
               rx_in    = tip_x_ff;
               lz_in    = tip_z_ff;
               rz_in    = tip_z_ff;
               row_in   = r0_ff;
               state_in = S_DIV_START;
            end
         end
         S_DIV_START: begin
            div_start = 1'b1;
            zero_w_in = div_den == '0;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_st.done)
               state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!ov_ff || rsp_bus.ready) begin
               ov_in     = 1'b1;
               o_row_in  = sat16(row_ff);
               o_xf_in   = sat16(round_fix(lx_ff));
               o_xl_in   = sat16(round_fix(rx_ff));
               o_dz_in   = lz_ff;
               o_step_in = zero_w_ff ? '0 : div_q;
               o_last_in = left_ff == ROWS_W'(1);
               lx_in     = sat_step(lx_ff, lxs_ff, up_ff);
               rx_in     = sat_step(rx_ff, rxs_ff, up_ff);
               lz_in     = sat_step(lz_ff, lzs_ff, up_ff);
               rz_in     = sat_step(rz_ff, rzs_ff, up_ff);
               row_in    = up_ff ? row_ff - 1'b1 : row_ff + 1'b1;
               left_in   = left_ff - 1'b1;
               state_in  = (left_ff == ROWS_W'(1)) ? S_IDLE : S_DIV_START;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      if (accept) begin
         tip_x_ff <= req_bus.tip_x;
         tip_y_ff <= req_bus.tip_y;
         tip_z_ff <= req_bus.tip_depth;
         end_ff   <= req_bus.end_row;
         lxs_ff   <= req_bus.left_x_slope;
         rxs_ff   <= req_bus.right_x_slope;
         lzs_ff   <= req_bus.left_z_slope;
         rzs_ff   <= req_bus.right_z_slope;
         color_ff <= req_bus.paint_color;
         up_ff    <= req_bus.upward;
      end
      r0_ff     <= r0_in;
      r1_ff     <= r1_in;
      row_ff    <= row_in;
      lx_ff     <= lx_in;
      rx_ff     <= rx_in;
      lz_ff     <= lz_in;
      rz_ff     <= rz_in;
      left_ff   <= left_in;
      trunc_ff  <= trunc_in;
      zero_w_ff <= zero_w_in;
      o_row_ff  <= o_row_in;
      o_xf_ff   <= o_xf_in;
      o_xl_ff   <= o_xl_in;
      o_dz_ff   <= o_dz_in;
      o_step_ff <= o_step_in;
      o_last_ff <= o_last_in;
   end

   // Color and truncation are loaded with each span into the output register
   logic [COLOR_W-1:0] o_color_ff;
   logic               o_trunc_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_EMIT && (!ov_ff || rsp_bus.ready)) begin
         o_color_ff <= color_ff;
         o_trunc_ff <= trunc_ff;
      end
   end

   assign req_bus.ready       = state_ff == S_IDLE;
   assign rsp_bus.valid       = ov_ff;
   assign rsp_bus.row         = o_row_ff;
   assign rsp_bus.x_first     = o_xf_ff;
   assign rsp_bus.x_final     = o_xl_ff;
   assign rsp_bus.depth_start = o_dz_ff;
   assign rsp_bus.depth_step  = o_step_ff;
   assign rsp_bus.span_color  = o_color_ff;
   assign rsp_bus.last        = o_last_ff;
   assign rsp_bus.truncated   = o_trunc_ff;

endmodule

// ===== src/tsr_div.sv =====
// Bit-serial restoring divider for the per-pixel depth step.
// Computes sat32((num << FRAC_BITS) / den), truncating toward zero. Uses tsr_pkg.
module tsr_div
   import tsr_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WORD_W:0]   num,
   input  logic signed [WORD_W:0]   den,
   output logic signed [WORD_W-1:0] quot,
   output div_status_type           status
);
   localparam int NUM_W = WORD_W + 1 + FRAC_BITS;   // shifted dividend
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]   dvd_ff,  dvd_in;
   logic [WORD_W:0]    rem_ff,  rem_in;
   logic [WORD_W:0]    dsr_ff,  dsr_in;
   logic [WORD_W-1:0]  q_ff,    q_in;
   logic               ovf_ff,  ovf_in;
   logic               neg_ff,  neg_in;
   logic [CNT_W-1:0]   cnt_ff,  cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [WORD_W:0]    num_mag;
   logic [WORD_W:0]    den_mag;
   logic [WORD_W+1:0]  rem_sh;
   logic [WORD_W+1:0]  rem_sub;
   logic               q_bit;
   logic               sat;

   assign num_mag = num[WORD_W] ? (WORD_W+1)'(-num) : num;
   assign den_mag = den[WORD_W] ? (WORD_W+1)'(-den) : den;

   // One quotient bit per cycle
   assign rem_sh  = {rem_ff, dvd_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};
   assign q_bit   = !rem_sub[WORD_W+1];

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = {num_mag, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         dsr_in  = den_mag;
         q_in    = '0;
         ovf_in  = 1'b0;
         neg_in  = num[WORD_W] ^ den[WORD_W];
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[NUM_W-2:0], 1'b0};
         rem_in = q_bit ? rem_sub[WORD_W:0] : rem_sh[WORD_W:0];
         q_in   = {q_ff[WORD_W-2:0], q_bit};
         ovf_in = ovf_ff | q_ff[WORD_W-1];   // a bit leaving the window
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   // Quotient of 2^31 or more saturates either way
   assign sat = ovf_ff | q_ff[WORD_W-1];
   always_comb begin
      if (sat)
         quot = neg_ff ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      else
         quot = neg_ff ? -q_ff : q_ff;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== src/tsr_checker.sv =====
// Port-level checks for the span rasterizer, bound to the top level.
// Depends on triangle_span_rasterizer and its channel interfaces.
module tsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_last,
   input logic [15:0] rsp_row
);
   // A waiting span keeps its row
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row))
      else $error("span changed while stalled");

   // A taken triangle blocks the input right after the transfer
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a transfer");

   // Nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("span valid after reset");

   // While a non-final span is shown more spans follow, so the input stays closed
   a_walk_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input ready in the middle of a walk");
endmodule

bind triangle_span_rasterizer tsr_checker u_tsr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_last  (rsp_bus.last),
   .rsp_row   (rsp_bus.row)
);

// ===== bench/tsr_tb_channels.sv =====
// Testbench constants: row limit and fraction bits of the default configuration.
// No dependencies; the channel interfaces come from src/tsr_channels.sv.
package tsr_tb_consts;
   localparam int SPAN_LIMIT = 64;
   localparam int FRAC       = 16;
endpackage

// ===== bench/triangle_span_rasterizer_tb.sv =====
// Testbench for triangle_span_rasterizer: drives triangles, predicts every span
// with an internal model, and compares each span transfer field by field.
// Depends on tsr_pkg, tsr_channels and tsr_tb_consts.
module triangle_span_rasterizer_tb;
   import tsr_pkg::*;
   import tsr_tb_consts::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] row;
      logic signed [15:0] x_first;
      logic signed [15:0] x_final;
      logic signed [31:0] depth_start;
      logic signed [31:0] depth_step;
      logic [7:0]         color;
      logic               last;
      logic               truncated;
   } span_t;

   typedef struct packed {
      logic signed [31:0] tx, ty, tz, er, lxs, rxs, lzs, rzs;
      logic [7:0]         color;
      logic               up;
   } tri_t;

   logic clock = 0;
   logic reset = 1;
   int   mismatches = 0;
   int   hold_cycles = 0;
   span_t expected_spans[$];

   tsr_req_if req_bus();
   tsr_rsp_if rsp_bus();

   triangle_span_rasterizer dut (.clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source));

   always #4 clock = ~clock;

   // fixed point helpers
   function automatic longint sat_to(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint round_half_away(longint v);
      longint half;
      half = longint'(1) <<< (FRAC - 1);
      if (v >= 0) return (v + half) >>> FRAC;
      return -(((-v) + half) >>> FRAC);
   endfunction

   function automatic longint per_pixel_depth(longint zl, longint zr, longint xl, longint xr);
      longint den, num, q;
      bit neg;
      longint unsigned un, ud, uq;
      den = xr - xl;
      num = zr - zl;
      neg = 0;
      if (den == 0) return 0;
      if (num < 0) begin neg = ~neg; un = -num; end else un = num;
      if (den < 0) begin neg = ~neg; ud = -den; end else ud = den;
      un = un << FRAC;
      uq = un / ud;
      if (uq > 64'h1_0000_0000) uq = 64'h1_0000_0000;
      q = longint'(uq);
      return sat_to(neg ? -q : q, -64'sd2147483648, 64'sd2147483647);
   endfunction

   // span predictor: walks rows and queues every expected span
   task automatic predict_spans(input tri_t t);
      longint r0, r1, count, n, row, lx, rx, lz, rz;
      span_t s;
      r0 = round_half_away(longint'(t.ty));
      r1 = round_half_away(longint'(t.er));
      count = t.up ? (r0 - r1 + 1) : (r1 - r0 + 1);
      if (count <= 0) return;
      n = count > SPAN_LIMIT ? SPAN_LIMIT : count;
      lx = t.tx; rx = t.tx; lz = t.tz; rz = t.tz; row = r0;
      for (longint k = 0; k < n; k++) begin
         s.row = 16'(sat_to(row, -32768, 32767));
         s.x_first = 16'(sat_to(round_half_away(lx), -32768, 32767));
         s.x_final = 16'(sat_to(round_half_away(rx), -32768, 32767));
         s.depth_start = 32'(lz);
         s.depth_step = 32'(per_pixel_depth(lz, rz, lx, rx));
         s.color = t.color;
         s.last = (k == n - 1);
         s.truncated = count > SPAN_LIMIT;
         expected_spans.push_back(s);
         if (t.up) begin
            lx = sat_to(lx - t.lxs, -64'sd2147483648, 64'sd2147483647);
            rx = sat_to(rx - t.rxs, -64'sd2147483648, 64'sd2147483647);
            lz = sat_to(lz - t.lzs, -64'sd2147483648, 64'sd2147483647);
            rz = sat_to(rz - t.rzs, -64'sd2147483648, 64'sd2147483647);
            row--;
         end else begin
            lx = sat_to(lx + t.lxs, -64'sd2147483648, 64'sd2147483647);
            rx = sat_to(rx + t.rxs, -64'sd2147483648, 64'sd2147483647);
            lz = sat_to(lz + t.lzs, -64'sd2147483648, 64'sd2147483647);
            rz = sat_to(rz + t.rzs, -64'sd2147483648, 64'sd2147483647);
            row++;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic int short_or_long_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
   endfunction

   // send one triangle; predict at the transfer edge; valid stays up for a
   // following triangle with no gap
   task automatic send_triangle(input tri_t t, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : short_or_long_gap();
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.tip_x <= t.tx; req_bus.tip_y <= t.ty; req_bus.tip_depth <= t.tz;
      req_bus.end_row <= t.er; req_bus.left_x_slope <= t.lxs;
      req_bus.right_x_slope <= t.rxs; req_bus.left_z_slope <= t.lzs;
      req_bus.right_z_slope <= t.rzs; req_bus.paint_color <= t.color;
      req_bus.upward <= t.up;
      do @(posedge clock); while (!req_bus.ready);
      predict_spans(t);
   endtask

   // Q16.16 helper for directed items
   function automatic logic signed [31:0] fx(input int whole, input int frac = 0);
      return (whole <<< 16) + frac;
   endfunction

   function automatic tri_t make_tri(int tx, int ty, int tz, int er, int lxs, int rxs,
                                     int lzs, int rzs, int color, bit up);
      tri_t t;
      t.tx = tx; t.ty = ty; t.tz = tz; t.er = er; t.lxs = lxs; t.rxs = rxs;
      t.lzs = lzs; t.rzs = rzs; t.color = color; t.up = up;
      return t;
   endfunction

   // random triangle, mostly short walks with random content
   function automatic tri_t random_triangle();
      tri_t t;
      int rows;
      t.tx = $urandom; t.tz = $urandom; t.lxs = $urandom; t.rxs = $urandom;
      t.lzs = $urandom; t.rzs = $urandom; t.color = $urandom; t.up = $urandom;
      t.ty = $urandom;
      t.er = $urandom;
      if ($urandom_range(0, 1)) begin
         t.tx = $signed(t.tx) >>> $urandom_range(0, 12);
         t.lxs = $signed(t.lxs) >>> $urandom_range(8, 20);
         t.rxs = $signed(t.rxs) >>> $urandom_range(8, 20);
      end
      // most walks get a bounded row count, a few keep the raw end row
      if ($urandom_range(0, 9) != 0) begin
         t.ty = $signed(t.ty) >>> $urandom_range(1, 8);
         if ($urandom_range(0, 9) == 1) rows = $urandom_range(60, 80);
         else rows = $urandom_range(0, 6);
         t.er = t.up ? t.ty - (rows <<< 16) + $urandom_range(0, 32767)
                     : t.ty + (rows <<< 16) - $urandom_range(0, 32767);
      end
      return t;
   endfunction

   // span checker with random stalls and a forced long hold-off
   initial begin
      span_t got, want;
      rsp_bus.ready <= 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.row, rsp_bus.x_first, rsp_bus.x_final, rsp_bus.depth_start,
                    rsp_bus.depth_step, rsp_bus.span_color, rsp_bus.last,
                    rsp_bus.truncated};
            if (expected_spans.size() == 0) report_mismatch("unexpected span", 0, 0);
            else begin
               want = expected_spans.pop_front();
               if (got.row != want.row) report_mismatch("row", got.row, want.row);
               if (got.x_first != want.x_first)
                  report_mismatch("x_first", got.x_first, want.x_first);
               if (got.x_final != want.x_final)
                  report_mismatch("x_final", got.x_final, want.x_final);
               if (got.depth_start != want.depth_start)
                  report_mismatch("depth_start", got.depth_start, want.depth_start);
               if (got.depth_step != want.depth_step)
                  report_mismatch("depth_step", got.depth_step, want.depth_step);
               if (got.color != want.color)
                  report_mismatch("span_color", got.color, want.color);
               if (got.last != want.last) report_mismatch("last", got.last, want.last);
               if (got.truncated != want.truncated)
                  report_mismatch("truncated", got.truncated, want.truncated);
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 0;
         end else if ($urandom_range(0, 3) == 0) rsp_bus.ready <= 0;
         else rsp_bus.ready <= 1;
      end
   end

   task automatic test_directed();
      // extremes, both directions, zero width, inverted span, empty walk, saturation
      send_triangle(make_tri(fx(10), fx(5), fx(1), fx(8), fx(-1), fx(1), fx(2), -fx(3),
                             8'h5a, 0));
      send_triangle(make_tri(fx(10), fx(5), fx(1), fx(2), fx(1), fx(-1), 0, fx(4),
                             8'ha5, 1));
      send_triangle(make_tri(fx(3), fx(0), fx(7), fx(3), 0, 0, fx(1), fx(2), 0, 0));
      send_triangle(make_tri(0, fx(0), 0, fx(3), fx(1), -fx(1), fx(5), 0, 8'hff, 0));
      send_triangle(make_tri(0, fx(4), 0, fx(2), 0, 0, 0, 0, 1, 0));
      send_triangle(make_tri(0, fx(2), 0, fx(4), 0, 0, 0, 0, 2, 1));
      send_triangle(make_tri(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                             32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                             3, 0));
      send_triangle(make_tri(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                             4, 1));
      send_triangle(make_tri(fx(1, 32768), fx(0, 32768), 0, fx(2, 32767),
                             fx(0, 32768), -fx(0, 32768), fx(1), -fx(1), 5, 0));
      send_triangle(make_tri(-fx(1, 32768), -fx(0, 32768), 0, -fx(3), fx(0, 32768),
                             -fx(0, 32768), 32'h7fffffff, 32'h80000000, 6, 1));
      send_triangle(make_tri(0, 0, 0, fx(70), fx(1), fx(2), fx(1), fx(3), 7, 0));
      send_triangle(make_tri(0, fx(100), 0, fx(36), fx(2), -fx(2), 1, -1, 8, 1));
      send_triangle(make_tri(0, 0, 0, fx(63), fx(1), fx(1), 0, 1, 9, 0));
      send_triangle(make_tri(0, 0, 0, fx(64), 0, 0, 0, 0, 10, 0));
      send_triangle(make_tri(fx(32000), fx(32760), 0, fx(32767), fx(300), -fx(300),
                             0, 0, 11, 0));
      send_triangle(make_tri(-fx(32000), -fx(32760), 0, -fx(32767), fx(300), -fx(300),
                             0, 0, 12, 1));
      send_triangle(make_tri(0, 0, 32'h7fffffff, fx(3), 1, 2, -1, 32'h80000000, 13, 0));
   endtask

   task automatic test_random();
      repeat (160) send_triangle(random_triangle());
   endtask

   // back-to-back triangles while the span side holds off
   task automatic test_backpressure();
      hold_cycles = 800;
      repeat (4) send_triangle(make_tri($urandom, fx(0), $urandom, fx(5), $urandom >> 12,
                                        $urandom >> 12, $urandom, $urandom,
                                        $urandom, 0), 1);
   endtask

   initial begin
      req_bus.valid <= 0;
      req_bus.tip_x <= 0; req_bus.tip_y <= 0; req_bus.tip_depth <= 0;
      req_bus.end_row <= 0; req_bus.left_x_slope <= 0; req_bus.right_x_slope <= 0;
      req_bus.left_z_slope <= 0; req_bus.right_z_slope <= 0;
      req_bus.paint_color <= 0; req_bus.upward <= 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      test_directed();
      test_backpressure();
      test_random();
      req_bus.valid <= 0;
      while (expected_spans.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   // watchdog: a limit well above the run time of all triangles, stalls included
   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
